[src/dtb_pkg.sv]
// dtb_pkg: shared types and constants for the delay timer bank
// depends on nothing; used by dtb_slot_bank and delay_timer_bank
package dtb_pkg;

  localparam int DEF_NUM_SLOTS = 16;
  localparam int SLOT_ID_W     = 5;
  localparam int TICK_W        = 32;
  localparam logic [TICK_W-1:0] TICK_MAX = 32'hffff_ffff;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [SLOT_ID_W-1:0]  slot_id;
    logic [TICK_W-1:0]     delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic id_valid;
    logic completed;
  } out_word_t;

  // write request into the slot store
  typedef struct packed {
    logic [SLOT_ID_W-1:0] slot_id;
    logic                 do_start;
    logic                 do_clear;
    logic [TICK_W-1:0]    delay_ticks;
  } slot_req_t;

  // read status of the addressed slot
  typedef struct packed {
    logic in_range;
    logic active;
    logic elapsed;
  } slot_stat_t;

endpackage

[src/dtb_slot_bank.sv]
// dtb_slot_bank: per-slot start, length and active storage with elapsed test
// depends on dtb_pkg
module dtb_slot_bank #(
  parameter int NUM_SLOTS = dtb_pkg::DEF_NUM_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dtb_pkg::slot_req_t            req_i,
  input  logic [dtb_pkg::TICK_W-1:0]    tick_i,
  output dtb_pkg::slot_stat_t           stat_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [dtb_pkg::TICK_W-1:0] start_r [NUM_SLOTS];
  logic [dtb_pkg::TICK_W-1:0] len_r   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       active_r, active_nxt;

  logic [IDX_W-1:0]         idx;
  logic                     in_range;
  logic [dtb_pkg::TICK_W:0] deadline;

  assign idx      = req_i.slot_id[IDX_W-1:0];
  assign in_range = ({1'b0, req_i.slot_id} < (dtb_pkg::SLOT_ID_W+1)'(NUM_SLOTS));

  // 33-bit deadline, no wrap handling
  assign deadline = {1'b0, start_r[idx]} + {1'b0, len_r[idx]};

  assign stat_o.in_range = in_range;
  assign stat_o.active   = in_range & active_r[idx];
  assign stat_o.elapsed  = ({1'b0, tick_i} >= deadline);

  always_comb begin
    active_nxt = active_r;
    if (in_range && req_i.do_start) begin
      active_nxt[idx] = 1'b1;
    end else if (in_range && req_i.do_clear) begin
      active_nxt[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_range && req_i.do_start) begin
      start_r[idx] <= tick_i;
      len_r[idx]   <= req_i.delay_ticks;
    end
  end

endmodule

[src/delay_timer_bank.sv]
// delay_timer_bank: top level of the delay slot bank with shared tick counter
// depends on dtb_pkg and dtb_slot_bank
//
// One word per clock: busy never rises, so start may be held high every
// cycle. A command is captured into an input register, executed against the
// tick counter and the slot store in the following cycle, and its result
// appears on out_word with out_strobe in the cycle after that.
// Every command yields one result word. The result is shown for a single
// cycle and cannot be stalled, so the receiver must take it whenever
// out_strobe is high. A command sees all effects of the one before it; no
// clearing pass is needed after reset.
module delay_timer_bank #(
  parameter int NUM_SLOTS = dtb_pkg::DEF_NUM_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dtb_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output dtb_pkg::out_word_t out_word
);

  logic                       item_vld_r;
  dtb_pkg::in_word_t          item_r;
  logic [dtb_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic                       strobe_r;
  dtb_pkg::out_word_t         res_r, res_nxt;

  dtb_pkg::slot_req_t  req;
  dtb_pkg::slot_stat_t stat;

  logic is_tick, is_start, is_stop, is_check;

  assign busy = 1'b0;

  assign is_tick  = item_vld_r && (item_r.command == dtb_pkg::CMD_TICK);
  assign is_start = item_vld_r && (item_r.command == dtb_pkg::CMD_START);
  assign is_stop  = item_vld_r && (item_r.command == dtb_pkg::CMD_STOP);
  assign is_check = item_vld_r && (item_r.command == dtb_pkg::CMD_CHECK);

  always_comb begin
    req.slot_id     = item_r.slot_id;
    req.delay_ticks = item_r.delay_ticks;
    req.do_start    = is_start;
    req.do_clear    = is_stop | (is_check & stat.active & stat.elapsed);
  end

  dtb_slot_bank #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (req),
    .tick_i (tick_r),
    .stat_o (stat)
  );

  always_comb begin
    tick_nxt = tick_r;
    if (is_tick) begin
      tick_nxt = (tick_r == dtb_pkg::TICK_MAX) ? '0 : tick_r + 1'b1;
    end
  end

  always_comb begin
    res_nxt.id_valid  = item_vld_r && !is_tick && stat.in_range;
    res_nxt.completed = is_check & stat.active & stat.elapsed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
      tick_r     <= '0;
    end else begin
      item_vld_r <= start & ~busy;
      strobe_r   <= item_vld_r;
      tick_r     <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_word;
    end
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = res_r;

endmodule
